FILE: rtl/triangle_lambert_flat_shade_assert.svh
// Assertion macros used by the triangle shading top level.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef TRIANGLE_LAMBERT_FLAT_SHADE_ASSERT_SVH
`define TRIANGLE_LAMBERT_FLAT_SHADE_ASSERT_SVH
`ifndef SYNTH
`define TLFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLFS_ASSERT(lbl, prop, msg)
`define TLFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/tlfs_pkg.sv
// Package for the flat Lambertian triangle shader: widths, latencies, word types.
// Depends on nothing.
`timescale 1ns / 1ps
package tlfs_pkg;

    localparam int COORD_W      = 32;
    localparam int DIFF_W       = 33;
    localparam int PROD_W       = 66;
    localparam int WV_W         = 35;
    localparam int NRM_IN_W     = 67;
    localparam int NORM_BITS    = 30;
    localparam int NV_W         = NORM_BITS + 1;
    localparam int LEN_W        = 7;
    localparam int SQ_W         = 62;
    localparam int ROOT_W       = 31;
    localparam int FRAC_W       = 16;
    localparam int STR_W        = 16;
    localparam int CENTROID_DIV = 3;

    localparam int NORM_LAT     = 4;
    localparam int SQRT_LAT     = 32;
    localparam int DIV_LAT      = FRAC_W + 1;
    localparam int FLAG_LEN     = SQRT_LAT + 1 + DIV_LAT;
    localparam int PIPE_DEPTH   = 3 + NORM_LAT + 2 + SQRT_LAT + 1 + DIV_LAT + 1;

    localparam logic [STR_W-1:0] STRENGTH_RESET = 16'd256;

    typedef enum logic [1:0] {
        REG_LIGHT_X,
        REG_LIGHT_Y,
        REG_LIGHT_Z,
        REG_LIGHT_STRENGTH
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_a_z;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_b_z;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
        logic signed [COORD_W-1:0] vert_c_z;
    } tri_word_t;

    typedef struct packed {
        logic [STR_W-1:0] lit_level;
        logic             degenerate;
    } shade_word_t;

    typedef struct packed {
        logic deg;
        logic dark;
    } flags_t;

endpackage

FILE: rtl/tlfs_norm.sv
// Four-stage vector normalizer: scales three signed components so the largest
// magnitude lies in [2^29, 2^30). Depends on tlfs_pkg.
`timescale 1ns / 1ps
module tlfs_norm
    import tlfs_pkg::*;
(
    input  logic                       clk,
    input  logic signed [NRM_IN_W-1:0] vec_in [3],
    output logic signed [NV_W-1:0]     vec_out [3],
    output logic                       nonzero
);

    logic [NRM_IN_W-1:0] mag1_reg [3];
    logic [2:0]          neg1_reg;
    logic [NRM_IN_W-1:0] mag2_reg [3];
    logic [2:0]          neg2_reg;
    logic [71:0]         or2_reg;
    logic [8:0]          grp2_reg;
    logic [NRM_IN_W-1:0] mag3_reg [3];
    logic [2:0]          neg3_reg;
    logic [LEN_W-1:0]    len3_reg;
    logic signed [NV_W-1:0] out4_reg [3];
    logic                nz4_reg;

    logic [71:0]      or_next;
    logic [8:0]       grp_next;
    logic [LEN_W-1:0] len_next;
    logic signed [NV_W-1:0] out_next [3];

    always_comb
    begin
        or_next = 72'({mag1_reg[0] | mag1_reg[1] | mag1_reg[2]});
        for (int g = 0; g < 9; g++)
        begin
            grp_next[g] = |or_next[g*8 +: 8];
        end
    end

    always_comb
    begin
        logic [3:0] gsel;
        logic [7:0] byte_sel;
        logic [3:0] blen;
        gsel = '0;
        blen = '0;
        for (int g = 0; g < 9; g++)
        begin
            if (grp2_reg[g])
            begin
                gsel = 4'(g);
            end
        end
        byte_sel = or2_reg[{gsel, 3'b000} +: 8];
        for (int b = 0; b < 8; b++)
        begin
            if (byte_sel[b])
            begin
                blen = 4'(b + 1);
            end
        end
        len_next = LEN_W'({gsel, 3'b000}) + LEN_W'(blen);
    end

    always_comb
    begin
        logic [NRM_IN_W+NORM_BITS-1:0] shifted;
        logic [NV_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            shifted = {mag3_reg[i], {NORM_BITS{1'b0}}} >> len3_reg;
            q = {1'b0, shifted[NORM_BITS-1:0]};
            out_next[i] = neg3_reg[i] ? -$signed(q) : $signed(q);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_reg[i] <= vec_in[i][NRM_IN_W-1];
            mag1_reg[i] <= vec_in[i][NRM_IN_W-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
            mag2_reg[i] <= mag1_reg[i];
            mag3_reg[i] <= mag2_reg[i];
            out4_reg[i] <= out_next[i];
        end
        neg2_reg <= neg1_reg;
        or2_reg  <= or_next;
        grp2_reg <= grp_next;
        neg3_reg <= neg2_reg;
        len3_reg <= len_next;
        nz4_reg  <= (len3_reg != '0);
    end

    assign vec_out = out4_reg;
    assign nonzero = nz4_reg;

endmodule

FILE: rtl/tlfs_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tlfs_pkg.
`timescale 1ns / 1ps
module tlfs_isqrt
    import tlfs_pkg::*;
(
    input  logic              clk,
    input  logic [SQ_W-1:0]   x,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W:0] xs_reg [SQRT_LAT];
    logic [SQ_W:0] rs_reg [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++)
    begin : g_step
        logic [SQ_W:0] x_cur;
        logic [SQ_W:0] r_cur;
        logic [SQ_W:0] bitv;
        logic [SQ_W:0] t;

        if (k == 0)
        begin : g_first
            assign x_cur = {1'b0, x};
            assign r_cur = '0;
        end
        else
        begin : g_rest
            assign x_cur = xs_reg[k-1];
            assign r_cur = rs_reg[k-1];
        end

        assign bitv = (SQ_W+1)'(1) << (SQ_W - 2*k);
        assign t    = r_cur + bitv;

        always_ff @(posedge clk)
        begin
            if (x_cur >= t)
            begin
                xs_reg[k] <= x_cur - t;
                rs_reg[k] <= (r_cur >> 1) + bitv;
            end
            else
            begin
                xs_reg[k] <= x_cur;
                rs_reg[k] <= r_cur >> 1;
            end
        end
    end

    assign root = rs_reg[SQRT_LAT-1][ROOT_W-1:0];

endmodule

FILE: rtl/tlfs_div.sv
// Pipelined restoring divider: one integer bit then sixteen fraction bits.
// Depends on tlfs_pkg.
`timescale 1ns / 1ps
module tlfs_div
    import tlfs_pkg::*;
(
    input  logic              clk,
    input  logic [SQ_W-1:0]   num,
    input  logic [SQ_W-1:0]   den,
    output logic [FRAC_W:0]   quo
);

    logic [SQ_W:0]   r_reg [DIV_LAT];
    logic [SQ_W-1:0] d_reg [DIV_LAT];
    logic [FRAC_W:0] q_reg [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_step
        logic [SQ_W:0]   rs;
        logic [SQ_W-1:0] d_cur;
        logic [FRAC_W:0] q_cur;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rs    = {1'b0, num};
            assign d_cur = den;
            assign q_cur = '0;
        end
        else
        begin : g_rest
            assign rs    = {r_reg[k-1][SQ_W-1:0], 1'b0};
            assign d_cur = d_reg[k-1];
            assign q_cur = q_reg[k-1];
        end

        assign ge = (rs >= {1'b0, d_cur});

        always_ff @(posedge clk)
        begin
            r_reg[k] <= ge ? (rs - {1'b0, d_cur}) : rs;
            d_reg[k] <= d_cur;
            q_reg[k] <= {q_cur[FRAC_W-1:0], ge};
        end
    end

    assign quo = q_reg[DIV_LAT-1];

endmodule

FILE: rtl/triangle_lambert_flat_shade.sv
// Flat Lambertian shader top level: cross product, light vector, normalizers,
// square roots, divider and intensity scaling. Depends on tlfs_pkg and submodules.
// One triangle is taken every cycle.
// The pipeline depth comes mostly from the 32-stage square root and 17-stage divider.
// busy is always low. Reset clears the valid line and loads the light registers.
`timescale 1ns / 1ps
`include "triangle_lambert_flat_shade_assert.svh"
module triangle_lambert_flat_shade
    import tlfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tri_word_t   triangle,
    output logic        done,
    output shade_word_t shade,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [COORD_W-1:0] light_x_reg;
    logic signed [COORD_W-1:0] light_y_reg;
    logic signed [COORD_W-1:0] light_z_reg;
    logic [STR_W-1:0]          light_strength_reg;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  accept;

    logic signed [COORD_W-1:0] va [3];
    logic signed [COORD_W-1:0] vb [3];
    logic signed [COORD_W-1:0] vc [3];
    logic signed [COORD_W-1:0] lp [3];

    logic signed [DIFF_W-1:0] d1_next [3];
    logic signed [DIFF_W-1:0] d2_next [3];
    logic signed [WV_W-1:0]   w_next [3];
    logic signed [DIFF_W-1:0] d1_reg [3];
    logic signed [DIFF_W-1:0] d2_reg [3];
    logic signed [WV_W-1:0]   w0_reg [3];
    logic signed [PROD_W-1:0] p1_reg [6];
    logic signed [WV_W-1:0]   w1_reg [3];
    logic signed [NRM_IN_W-1:0] n2_reg [3];
    logic signed [NRM_IN_W-1:0] w2_reg [3];

    logic signed [NV_W-1:0] nv [3];
    logic signed [NV_W-1:0] wv [3];
    logic                   nz_n;
    logic                   nz_w;

    logic signed [SQ_W-1:0] dt7_reg [3];
    logic [SQ_W-1:0]        nq7_reg [3];
    logic [SQ_W-1:0]        wq7_reg [3];
    logic                   deg7_reg;

    logic signed [SQ_W:0]   dot_sum;
    logic [SQ_W-1:0]        dot8_reg;
    logic [SQ_W-1:0]        nn8_reg;
    logic [SQ_W-1:0]        ww8_reg;
    flags_t                 fl8_reg;

    logic [SQ_W-1:0] dot_dly_reg [SQRT_LAT];
    flags_t          fl_dly_reg [FLAG_LEN];

    logic [ROOT_W-1:0] rn;
    logic [ROOT_W-1:0] rw;
    logic [SQ_W-1:0]   den41_reg;
    logic [SQ_W-1:0]   dot41_reg;
    logic [FRAC_W:0]   quo;

    shade_word_t shade_reg;
    shade_word_t shade_next;

    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg        <= '0;
            light_y_reg        <= '0;
            light_z_reg        <= '0;
            light_strength_reg <= STRENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LIGHT_X:        light_x_reg        <= cfg_data;
                REG_LIGHT_Y:        light_y_reg        <= cfg_data;
                REG_LIGHT_Z:        light_z_reg        <= cfg_data;
                REG_LIGHT_STRENGTH: light_strength_reg <= cfg_data[STR_W-1:0];
                default:            light_x_reg        <= light_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    always_comb
    begin
        logic signed [WV_W-1:0] lp3;
        logic signed [WV_W-1:0] vsum;
        va[0] = triangle.vert_a_x;
        va[1] = triangle.vert_a_y;
        va[2] = triangle.vert_a_z;
        vb[0] = triangle.vert_b_x;
        vb[1] = triangle.vert_b_y;
        vb[2] = triangle.vert_b_z;
        vc[0] = triangle.vert_c_x;
        vc[1] = triangle.vert_c_y;
        vc[2] = triangle.vert_c_z;
        lp[0] = light_x_reg;
        lp[1] = light_y_reg;
        lp[2] = light_z_reg;
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = DIFF_W'(va[i]) - DIFF_W'(vc[i]);
            d2_next[i] = DIFF_W'(vb[i]) - DIFF_W'(vc[i]);
            lp3 = WV_W'(lp[i]) * WV_W'(CENTROID_DIV);
            vsum = WV_W'(va[i]) + WV_W'(vb[i]) + WV_W'(vc[i]);
            w_next[i] = lp3 - vsum;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i] <= d1_next[i];
            d2_reg[i] <= d2_next[i];
            w0_reg[i] <= w_next[i];
            w1_reg[i] <= w0_reg[i];
            w2_reg[i] <= NRM_IN_W'(w1_reg[i]);
        end
        p1_reg[0] <= PROD_W'(d1_reg[1]) * PROD_W'(d2_reg[2]);
        p1_reg[1] <= PROD_W'(d1_reg[2]) * PROD_W'(d2_reg[1]);
        p1_reg[2] <= PROD_W'(d1_reg[2]) * PROD_W'(d2_reg[0]);
        p1_reg[3] <= PROD_W'(d1_reg[0]) * PROD_W'(d2_reg[2]);
        p1_reg[4] <= PROD_W'(d1_reg[0]) * PROD_W'(d2_reg[1]);
        p1_reg[5] <= PROD_W'(d1_reg[1]) * PROD_W'(d2_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            n2_reg[i] <= NRM_IN_W'(p1_reg[2*i]) - NRM_IN_W'(p1_reg[2*i+1]);
        end
    end

    tlfs_norm u_norm_n
    (
        .clk     (clk),
        .vec_in  (n2_reg),
        .vec_out (nv),
        .nonzero (nz_n)
    );

    tlfs_norm u_norm_w
    (
        .clk     (clk),
        .vec_in  (w2_reg),
        .vec_out (wv),
        .nonzero (nz_w)
    );

    assign dot_sum = (SQ_W+1)'(dt7_reg[0]) + (SQ_W+1)'(dt7_reg[1]) + (SQ_W+1)'(dt7_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dt7_reg[i] <= SQ_W'(nv[i]) * SQ_W'(wv[i]);
            nq7_reg[i] <= SQ_W'(SQ_W'(nv[i]) * SQ_W'(nv[i]));
            wq7_reg[i] <= SQ_W'(SQ_W'(wv[i]) * SQ_W'(wv[i]));
        end
        deg7_reg <= !(nz_n && nz_w);

        dot8_reg     <= dot_sum[SQ_W-1:0];
        nn8_reg      <= nq7_reg[0] + nq7_reg[1] + nq7_reg[2];
        ww8_reg      <= wq7_reg[0] + wq7_reg[1] + wq7_reg[2];
        fl8_reg.deg  <= deg7_reg;
        fl8_reg.dark <= deg7_reg || dot_sum[SQ_W] || (dot_sum == '0);

        dot_dly_reg[0] <= dot8_reg;
        fl_dly_reg[0]  <= fl8_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            dot_dly_reg[k] <= dot_dly_reg[k-1];
        end
        for (int k = 1; k < FLAG_LEN; k++)
        begin
            fl_dly_reg[k] <= fl_dly_reg[k-1];
        end

        den41_reg <= SQ_W'(rn) * SQ_W'(rw);
        dot41_reg <= dot_dly_reg[SQRT_LAT-1];

        shade_reg <= shade_next;
    end

    tlfs_isqrt u_sqrt_n
    (
        .clk  (clk),
        .x    (nn8_reg),
        .root (rn)
    );

    tlfs_isqrt u_sqrt_w
    (
        .clk  (clk),
        .x    (ww8_reg),
        .root (rw)
    );

    tlfs_div u_div
    (
        .clk (clk),
        .num (dot41_reg),
        .den (den41_reg),
        .quo (quo)
    );

    always_comb
    begin
        logic [2*STR_W-1:0] prod;
        prod = quo[FRAC_W-1:0] * light_strength_reg;
        shade_next.degenerate = fl_dly_reg[FLAG_LEN-1].deg;
        if (fl_dly_reg[FLAG_LEN-1].dark)
        begin
            shade_next.lit_level = '0;
        end
        else if (quo[FRAC_W])
        begin
            shade_next.lit_level = light_strength_reg;
        end
        else
        begin
            shade_next.lit_level = prod[2*STR_W-1:FRAC_W];
        end
    end

    assign done  = valid_reg[PIPE_DEPTH-1];
    assign shade = shade_reg;

    `TLFS_ASSERT(a_deg_dark, done && shade.degenerate |-> shade.lit_level == '0, "degenerate result not dark")
    `TLFS_ASSERT(a_lit_bound, done |-> shade.lit_level <= light_strength_reg, "lit level above intensity")
    `TLFS_ASSERT(a_latency, accept |-> ##PIPE_DEPTH done, "accepted word produced no result")
    `TLFS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !done || rst_n, "result during reset")

endmodule
